// ===== sv/u8u16_pkg.sv =====
// Package for the UTF-8 to UTF-16 decoder: the command passed from front to back
// and the byte and code point constants. Depends on nothing.
package u8u16_pkg;

    localparam int POINT_W = 21;
    localparam int UNIT_W  = 16;
    localparam int BYTE_W  = 8;

    localparam logic [BYTE_W-1:0]  LEAD2_MIN   = 8'hC0;
    localparam logic [BYTE_W-1:0]  LEAD3_MIN   = 8'hE0;
    localparam logic [BYTE_W-1:0]  LEAD4_MIN   = 8'hF0;
    localparam logic [BYTE_W-1:0]  LEAD_BAD    = 8'hF7;
    localparam logic [1:0]         CONT_TAG    = 2'b10;
    localparam logic [POINT_W-1:0] SUPP_BASE   = 21'h10000;
    localparam logic [5:0]         HIGH_TAG    = 6'b110110;
    localparam logic [5:0]         LOW_TAG     = 6'b110111;

    typedef struct packed {
        logic               is_error;
        logic [POINT_W-1:0] value;
    } cmd_t;

endpackage

// ===== sv/u8u16_front.sv =====
// Front of the UTF-8 to UTF-16 decoder: accepts bytes, tracks the partial code
// point and emits one command per finished code point or error. Uses u8u16_pkg.
module u8u16_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // byte_in
    input  logic                 s_tlast,   // end_of_string
    input  logic                 q_full,
    output logic                 push,
    output u8u16_pkg::cmd_t      push_cmd
);

    logic [u8u16_pkg::POINT_W-1:0] pv_reg, pv_next;
    logic [1:0]                    pend_reg, pend_next;
    logic                          disc_reg, disc_next;
    logic                          accept;
    logic                          emit;
    logic                          emit_err;
    logic [u8u16_pkg::POINT_W-1:0] emit_val;
    logic [u8u16_pkg::POINT_W-1:0] shifted;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign shifted  = {pv_reg[u8u16_pkg::POINT_W-7:0], s_tdata[5:0]};

    always_comb
    begin
        pv_next   = pv_reg;
        pend_next = pend_reg;
        disc_next = disc_reg;
        emit      = 1'b0;
        emit_err  = 1'b0;
        emit_val  = '0;
        if (disc_reg)
        begin
            emit = 1'b0;
        end
        else if (pend_reg == 2'd0)
        begin
            if (!s_tdata[7])
            begin
                emit     = 1'b1;
                emit_val = {{(u8u16_pkg::POINT_W-8){1'b0}}, s_tdata};
            end
            else if (s_tdata < u8u16_pkg::LEAD2_MIN || s_tdata >= u8u16_pkg::LEAD_BAD)
            begin
                emit      = 1'b1;
                emit_err  = 1'b1;
                disc_next = !s_tlast;
            end
            else if (s_tdata < u8u16_pkg::LEAD3_MIN)
            begin
                pend_next = 2'd1;
                pv_next   = {{(u8u16_pkg::POINT_W-5){1'b0}}, s_tdata[4:0]};
                emit      = s_tlast;
                emit_err  = s_tlast;
            end
            else if (s_tdata < u8u16_pkg::LEAD4_MIN)
            begin
                pend_next = 2'd2;
                pv_next   = {{(u8u16_pkg::POINT_W-4){1'b0}}, s_tdata[3:0]};
                emit      = s_tlast;
                emit_err  = s_tlast;
            end
            else
            begin
                pend_next = 2'd3;
                pv_next   = {{(u8u16_pkg::POINT_W-3){1'b0}}, s_tdata[2:0]};
                emit      = s_tlast;
                emit_err  = s_tlast;
            end
        end
        else if (s_tdata[7:6] != u8u16_pkg::CONT_TAG)
        begin
            emit      = 1'b1;
            emit_err  = 1'b1;
            pv_next   = '0;
            pend_next = 2'd0;
            disc_next = !s_tlast;
        end
        else
        begin
            pend_next = pend_reg - 2'd1;
            if (pend_reg == 2'd1)
            begin
                emit     = 1'b1;
                emit_val = shifted;
                pv_next  = '0;
            end
            else
            begin
                pv_next  = shifted;
                emit     = s_tlast;
                emit_err = s_tlast;
            end
        end
        if (emit_err)
        begin
            emit_val = '0;
            if (!disc_next)
            begin
                pv_next   = '0;
                pend_next = 2'd0;
            end
        end
        if (emit_err && disc_next)
        begin
            pv_next   = '0;
            pend_next = 2'd0;
        end
        if (s_tlast)
        begin
            pv_next   = '0;
            pend_next = 2'd0;
            disc_next = 1'b0;
        end
    end

    assign push              = accept && emit;
    assign push_cmd.is_error = emit_err;
    assign push_cmd.value    = emit_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg   <= '0;
            pend_reg <= 2'd0;
            disc_reg <= 1'b0;
        end
        else if (accept)
        begin
            pv_reg   <= pv_next;
            pend_reg <= pend_next;
            disc_reg <= disc_next;
        end
    end

endmodule

// ===== sv/u8u16_queue.sv =====
// Short command queue between the front and back of the UTF-8 to UTF-16 decoder.
// Uses u8u16_pkg for the command type.
module u8u16_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  u8u16_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output u8u16_pkg::cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    u8u16_pkg::cmd_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/u8u16_back.sv =====
// Back of the UTF-8 to UTF-16 decoder: turns commands into code units or
// surrogate pairs behind an output register. Uses u8u16_pkg.
module u8u16_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  u8u16_pkg::cmd_t head_cmd,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [15:0]     m_tdata,   // code_unit
    output logic            m_tuser,   // kind
    output logic            m_tlast    // last_of_run
);

    logic                          valid_reg;
    logic [15:0]                   unit_reg;
    logic                          kind_reg;
    logic                          last_reg;
    logic                          low_pend_reg;
    logic [9:0]                    low_bits_reg;
    logic                          load;
    logic                          is_supp;
    logic [u8u16_pkg::POINT_W-1:0] offset;

    assign load    = !valid_reg || m_tready;
    assign pop     = load && !low_pend_reg && head_valid;
    assign is_supp = (head_cmd.value >= u8u16_pkg::SUPP_BASE);
    assign offset  = head_cmd.value - u8u16_pkg::SUPP_BASE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            low_pend_reg <= 1'b0;
        end
        else if (load)
        begin
            if (low_pend_reg)
            begin
                valid_reg    <= 1'b1;
                low_pend_reg <= 1'b0;
            end
            else
            begin
                valid_reg    <= head_valid;
                low_pend_reg <= head_valid && !head_cmd.is_error && is_supp;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (low_pend_reg)
            begin
                unit_reg <= {u8u16_pkg::LOW_TAG, low_bits_reg};
                kind_reg <= 1'b0;
                last_reg <= 1'b1;
            end
            else if (head_cmd.is_error)
            begin
                unit_reg <= '0;
                kind_reg <= 1'b1;
                last_reg <= 1'b1;
            end
            else if (is_supp)
            begin
                unit_reg     <= {u8u16_pkg::HIGH_TAG, offset[19:10]};
                kind_reg     <= 1'b0;
                last_reg     <= 1'b0;
                low_bits_reg <= head_cmd.value[9:0];
            end
            else
            begin
                unit_reg <= head_cmd.value[15:0];
                kind_reg <= 1'b0;
                last_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = unit_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== sv/utf8_to_utf16_decoder.sv =====
// Top level of the UTF-8 to UTF-16 decoder.
// Instantiates u8u16_front, u8u16_queue and u8u16_back; uses u8u16_pkg.
//
// Usage:
// The slave channel takes one UTF-8 byte per item in s_tdata, with s_tlast set
// on the final byte of a string. The master channel gives one UTF-16 code unit
// per item in m_tdata; m_tuser is high on an error item, whose data is zero, and
// m_tlast marks the final result caused by one input byte.
// Code points at or above 0x10000 leave as a surrogate pair, high unit first.
// After an error the rest of the string is dropped without results.
// Bytes are taken one per cycle while the command queue is not full; a
// surrogate pair occupies the output for both of its units, and the command
// queue absorbs the difference. An accepted byte's command is written into
// the command queue first and then loaded into the output register.
// Reset clears the decoding state, the queue and the output register.
// When the receiver stalls, the output holds, the queue fills, and s_tready
// drops once FIFO_DEPTH commands are waiting.
module utf8_to_utf16_decoder
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_in
    input  logic        s_tlast,   // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // code_unit
    output logic        m_tuser,   // kind
    output logic        m_tlast    // last_of_run
);

    logic            q_full;
    logic            push;
    u8u16_pkg::cmd_t push_cmd;
    logic            pop;
    logic            head_valid;
    u8u16_pkg::cmd_t head_cmd;

    u8u16_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    u8u16_queue #(.DEPTH(FIFO_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    u8u16_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== sv/u8u16_checker.sv =====
// Port-level checks for the UTF-8 to UTF-16 decoder, bound to the top level.
// Depends on utf8_to_utf16_decoder.
module u8u16_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 16'h0000 && m_tlast)
        else $error("error item carries data or is not last");

    a_high_surrogate: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !m_tuser && m_tdata[15:10] == 6'b110110)
        else $error("non-last item is not a high surrogate");

    a_low_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && m_tlast && !m_tuser && m_tdata[15:10] == 6'b110111)
        else $error("high surrogate not followed by low surrogate");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output item changed");

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
